FILE: design/bsle_pkg.sv
// Shared types and codes for the bounded sequence list engine.
package bsle_pkg;

    // Operation codes carried by an input word.
    localparam logic [2:0] OP_INS    = 3'd0;
    localparam logic [2:0] OP_DEL    = 3'd1;
    localparam logic [2:0] OP_ORD    = 3'd2;
    localparam logic [2:0] OP_REV    = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;
    localparam logic [2:0] OP_DUMP   = 3'd5;

    // Status codes carried by a result word.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the input word, clear step counter
        logic rot;     // rotate all cells left by one
        logic rev;     // reverse all cells
        logic shd;     // shift cells down by one
        logic scan;    // compare the head cell at this step
        logic kinc;    // advance step counter
        logic kcnt;    // load step counter with the element count
        logic exec;    // finish the operation, update count
        logic emit;    // load a dump word into the output register
        logic result;  // load the final result word
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic k_last;
        logic k_done;
        logic dump_last;
        logic out_free;
    } sts_t;

endpackage

FILE: design/bsle_ctrl.sv
// Controller state machine of the bounded sequence list engine.
module bsle_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [2:0]     op,
    input  bsle_pkg::sts_t sts,
    output logic           in_ready,
    output bsle_pkg::cmd_t cmd
);
    import bsle_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SCAN   = 8'b00000010,
        S_REV    = 8'b00000100,
        S_SHIFT  = 8'b00001000,
        S_DUMP   = 8'b00010000,
        S_ROT    = 8'b00100000,
        S_EXEC   = 8'b01000000,
        S_RESULT = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (op)
                        OP_ORD, OP_SEARCH: state_next = S_SCAN;
                        OP_REV:            state_next = S_REV;
                        OP_DUMP:           state_next = sts.empty ? S_EXEC : S_DUMP;
                        default:           state_next = S_EXEC;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.rot  = 1'b1;
                cmd.scan = 1'b1;
                cmd.kinc = 1'b1;
                if (sts.k_last)
                    state_next = S_EXEC;
            end
            S_REV:
            begin
                cmd.rev    = 1'b1;
                cmd.kcnt   = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.k_done)
                    state_next = S_EXEC;
                else
                begin
                    cmd.shd  = 1'b1;
                    cmd.kinc = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.rot  = 1'b1;
                    cmd.kinc = 1'b1;
                    if (sts.dump_last)
                        state_next = sts.k_last ? S_IDLE : S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rot  = 1'b1;
                cmd.kinc = 1'b1;
                if (sts.k_last)
                    state_next = S_IDLE;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/bsle_dpath.sv
// Datapath of the bounded sequence list engine: cell row, counters, output word.
module bsle_dpath
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bsle_pkg::cmd_t      cmd,
    output bsle_pkg::sts_t      sts,
    input  logic [2:0]          op,
    input  logic signed [31:0]  value,
    input  logic [4:0]          position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic signed [31:0]  item_value,
    output logic [4:0]          item_index,
    output logic [4:0]          length,
    output logic                last
);
    import bsle_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [DATA_WIDTH-1:0] cell_reg [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_next [CAPACITY];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         k_reg;
    logic [CW-1:0]         found_reg;
    logic                  found_flag_reg;
    logic [2:0]            op_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [4:0]            pos_reg;
    logic [2:0]            res_st_reg;
    logic [CW-1:0]         res_idx_reg;
    logic                  ov_reg;
    logic [2:0]            st_o_reg;
    logic [31:0]           val_o_reg;
    logic [4:0]            idx_o_reg;
    logic [4:0]            len_o_reg;
    logic                  last_o_reg;

    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [CMPW-1:0]       ipos;
    logic                  full;
    logic                  ins_go;
    logic                  del_go;
    logic [2:0]            ex_st;
    logic [CW-1:0]         ex_idx;
    logic                  hit;
    logic                  k_in;
    logic signed [63:0]    val_wide;
    logic signed [63:0]    head_wide;

    assign pos_ext   = CMPW'(pos_reg);
    assign cnt_ext   = CMPW'(count_reg);
    assign full      = (count_reg == CW'(CAPACITY));
    assign k_in      = (k_reg < count_reg);
    assign val_wide  = 64'(value);
    assign head_wide = 64'(signed'(cell_reg[0]));

    // Status toward the controller.
    assign sts.empty     = (count_reg == '0);
    assign sts.k_last    = (k_reg == CW'(CAPACITY - 1));
    assign sts.k_done    = (k_reg == CW'(CAPACITY));
    assign sts.dump_last = (CW'(k_reg + 1'b1) == count_reg);
    assign sts.out_free  = !ov_reg || out_ready;

    // Head cell compare for search and ordered insert.
    always_comb
    begin
        hit = 1'b0;
        if (cmd.scan && !found_flag_reg && k_in)
        begin
            if (op_reg == OP_SEARCH)
                hit = (cell_reg[0] == val_reg);
            else if (k_reg == '0)
                hit = $signed(val_reg) < $signed(cell_reg[0]);
            else
                hit = !($signed(cell_reg[0]) < $signed(val_reg));
        end
    end

    // Final decision of each operation.
    always_comb
    begin
        ins_go = 1'b0;
        del_go = 1'b0;
        ipos   = pos_ext;
        ex_st  = ST_OK;
        ex_idx = '0;
        case (op_reg)
            OP_INS:
            begin
                if (pos_ext > cnt_ext)
                    ex_st = ST_BADPOS;
                else if (full)
                    ex_st = ST_FULL;
                else
                    ins_go = 1'b1;
            end
            OP_DEL:
            begin
                if (count_reg == '0)
                    ex_st = ST_EMPTY;
                else if (pos_ext >= cnt_ext)
                    ex_st = ST_BADPOS;
                else
                    del_go = 1'b1;
            end
            OP_ORD:
            begin
                ipos = found_flag_reg ? CMPW'(found_reg) : cnt_ext;
                if (full)
                    ex_st = ST_FULL;
                else
                    ins_go = 1'b1;
            end
            OP_SEARCH:
            begin
                if (count_reg == '0)
                    ex_st = ST_EMPTY;
                else if (found_flag_reg)
                    ex_idx = found_reg;
                else
                    ex_st = ST_NOTFOUND;
            end
            OP_DUMP: ex_st = ST_EMPTY;
            default: ex_st = ST_OK;
        endcase
    end

    // Next value of each cell; every cell sees only fixed neighbors.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.exec && ins_go)
            begin
                if (CMPW'(i) == ipos)
                    cell_next[i] = val_reg;
                else if (CMPW'(i) > ipos)
                    cell_next[i] = cell_reg[(i + CAPACITY - 1) % CAPACITY];
            end
            else if (cmd.exec && del_go)
            begin
                if (CMPW'(i) >= pos_ext && i < CAPACITY - 1)
                    cell_next[i] = cell_reg[i + 1 - ((i + 1) / CAPACITY)];
            end
            else if (cmd.rot)
                cell_next[i] = cell_reg[(i + 1) % CAPACITY];
            else if (cmd.rev)
                cell_next[i] = cell_reg[CAPACITY - 1 - i];
            else if (cmd.shd && i < CAPACITY - 1)
                cell_next[i] = cell_reg[i + 1 - ((i + 1) / CAPACITY)];
        end
    end

    // Count update.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && ins_go)
            count_next = count_reg + 1'b1;
        else if (cmd.exec && del_go)
            count_next = count_reg - 1'b1;
    end

    // Cell row, operand, match, result and output word registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            cell_reg[i] <= cell_next[i];
        if (cmd.load)
        begin
            op_reg  <= op;
            val_reg <= val_wide[DATA_WIDTH-1:0];
            pos_reg <= position;
        end
        if (hit)
            found_reg <= k_reg;
        if (cmd.exec)
        begin
            res_st_reg  <= ex_st;
            res_idx_reg <= ex_idx;
        end
        if (cmd.emit)
        begin
            st_o_reg   <= ST_OK;
            val_o_reg  <= head_wide[31:0];
            idx_o_reg  <= 5'(CMPW'(k_reg));
            len_o_reg  <= cnt_ext[4:0];
            last_o_reg <= sts.dump_last;
        end
        else if (cmd.result)
        begin
            st_o_reg   <= res_st_reg;
            val_o_reg  <= '0;
            idx_o_reg  <= 5'(CMPW'(res_idx_reg));
            len_o_reg  <= cnt_ext[4:0];
            last_o_reg <= 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            k_reg          <= '0;
            found_flag_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
                k_reg <= '0;
            else if (cmd.kcnt)
                k_reg <= count_reg;
            else if (cmd.kinc)
                k_reg <= k_reg + 1'b1;
            if (cmd.load)
                found_flag_reg <= 1'b0;
            else if (hit)
                found_flag_reg <= 1'b1;
            if (cmd.emit || cmd.result)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid  = ov_reg;
    assign status     = st_o_reg;
    assign item_value = val_o_reg;
    assign item_index = idx_o_reg;
    assign length     = len_o_reg;
    assign last       = last_o_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A new result word never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.result) |-> (!ov_reg || out_ready))
        else $error("output word overwritten");

    // A recorded match always lies inside the stored elements.
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        found_flag_reg |-> (found_reg < count_reg))
        else $error("match index outside the list");

endmodule

FILE: design/bounded_sequence_list_engine.sv
// Top level of the bounded sequence list engine: controller plus datapath.
// Insert, delete, empty dump and unused codes: execute, then the result word. Ordered insert
// and search: a rotating scan of all cells first. Reverse: CAPACITY - count shifts follow the
// reversal. Dump: a word a cycle while the output is free, then CAPACITY - count rotations.
// One word is worked at a time; the next is taken when the previous finishes.
// Reset clears the count and the control; cell contents stay undefined until written.
module bounded_sequence_list_engine
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    input  logic [4:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] item_value,
    output logic [4:0]         item_index,
    output logic [4:0]         length,
    output logic               last
);
    import bsle_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencing of each operation.
    bsle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Cell row, counters and output word.
    bsle_dpath
    #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .item_value (item_value),
        .item_index (item_index),
        .length     (length),
        .last       (last)
    );

endmodule
